// ----- sv/lpjm_pkg.sv -----
// lpjm_pkg: shared constants, types and helpers of the loop period jitter monitor
// used by lpjm_ctrl, lpjm_dp and loop_period_jitter_monitor; no dependencies
package lpjm_pkg;

    localparam int WINDOW_DEF = 128;
    localparam int WINDOW_MAX = 1024;
    localparam int TS_W       = 48;
    localparam int TGT_W      = 24;
    localparam int THR_W      = 8;
    localparam int CNT_W      = 32;
    localparam int WS_W       = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int RES_W      = 432;
    localparam int RANK_W     = $clog2(WINDOW_MAX + 1);

    localparam logic [TGT_W-1:0] TGT_RST = TGT_W'(1000);
    localparam logic [THR_W-1:0] THR_RST = THR_W'(5);

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = CFG_IDX_W'(1);

    localparam logic [6:0] PCT_50 = 7'd50;
    localparam logic [6:0] PCT_95 = 7'd95;
    localparam logic [6:0] PCT_99 = 7'd99;

    // reciprocal of 100 scaled by 2^24, exact for products below 2^17
    localparam int RECIP_SH = 24;
    localparam logic [17:0] RECIP_100 = 18'd167773;

    typedef struct packed {
        logic accept;
        logic meas;
        logic div_step;
        logic upd;
        logic rank;
        logic pass_step;
        logic swap;
        logic fin;
    } ctrl_cmd_t;

    typedef struct packed {
        logic valid;
        logic overrun;
        logic div_done;
        logic pass_done;
    } dp_sts_t;

    // ceil(pct * n / 100) through a reciprocal multiply
    function automatic logic [RANK_W-1:0] rank_of(input logic [RANK_W-1:0] n,
                                                  input logic [6:0] pct);
        logic [17:0] x;
        logic [35:0] prod;
        x    = 18'(pct) * 18'(n) + 18'd99;
        prod = x * RECIP_100;
        return RANK_W'(prod >> RECIP_SH);
    endfunction

endpackage

// ----- sv/lpjm_ctrl.sv -----
// lpjm_ctrl: sequencing state machine of the jitter monitor
// depends on lpjm_pkg; drives lpjm_dp through ctrl_cmd_t and reads dp_sts_t
module lpjm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  lpjm_pkg::dp_sts_t  sts,
    output lpjm_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MEAS = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_UPD  = 7'b0001000,
        ST_RANK = 7'b0010000,
        ST_PASS = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_vld_reg, out_vld_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_vld_reg;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_MEAS;
                end
            end
            ST_MEAS: begin
                cmd.meas   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!sts.valid) begin
                    state_next = ST_FIN;
                end else if (!sts.overrun || sts.div_done) begin
                    state_next = ST_UPD;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = ST_RANK;
            end
            ST_RANK: begin
                cmd.rank   = 1'b1;
                state_next = ST_PASS;
            end
            ST_PASS: begin
                if (sts.pass_done) begin
                    cmd.swap   = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    cmd.pass_step = 1'b1;
                end
            end
            ST_FIN: begin
                if (!out_vld_reg || m_tready) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output register occupancy
    always_comb begin
        out_vld_next = out_vld_reg;
        if (cmd.fin) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    a_accept_meas: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_MEAS))
        else $error("accepted item did not start measurement");

    a_pass_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.swap |=> (state_reg == ST_FIN))
        else $error("merge pass did not end in result stage");

    a_no_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && sts.valid && !sts.overrun) |=> (state_reg == ST_UPD))
        else $error("divider ran without overrun");

    a_fin_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |=> m_tvalid)
        else $error("result not presented after load");

endmodule

// ----- sv/lpjm_dp.sv -----
// lpjm_dp: datapath of the jitter monitor: stats, divider, interval ring,
// sorted window banks and result register; depends on lpjm_pkg
module lpjm_dp #(
    parameter int WINDOW = lpjm_pkg::WINDOW_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lpjm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lpjm_pkg::TGT_W-1:0]          cfg_wr_data,
    input  logic [lpjm_pkg::TS_W-1:0]           s_tdata,
    output logic [lpjm_pkg::RES_W-1:0]          m_tdata,
    input  lpjm_pkg::ctrl_cmd_t                 cmd,
    output lpjm_pkg::dp_sts_t                   sts
);

    localparam int TS_W  = lpjm_pkg::TS_W;
    localparam int CW    = lpjm_pkg::CNT_W;
    localparam int WS_W  = lpjm_pkg::WS_W;
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int N_W   = $clog2(WINDOW + 1);
    localparam int DIV_W = $clog2(TS_W + 1);
    localparam logic [N_W-1:0]   N_FULL  = N_W'(WINDOW);
    localparam logic [IDX_W-1:0] POS_END = IDX_W'(WINDOW - 1);
    localparam logic [CW-1:0]    CNT_MAX = '1;
    localparam logic [TS_W-1:0]  TS_MAX  = '1;

    // configuration
    logic [lpjm_pkg::TGT_W-1:0] tgt_reg;
    logic [lpjm_pkg::THR_W-1:0] thr_reg;

    // per-item values
    logic [TS_W-1:0] now_reg, last_reg, dt_reg, evict_reg;
    logic            valid_reg;

    // statistics
    logic [TS_W-1:0] jpk_reg, psum_reg;
    logic [CW-1:0]   oev_reg, run_reg, rpk_reg, cross_reg;

    // divider
    logic [lpjm_pkg::TGT_W-1:0] rem_reg;
    logic [TS_W-1:0]            quo_reg;
    logic [DIV_W-1:0]           div_cnt_reg;

    // ring and window bookkeeping
    logic [IDX_W-1:0] pos_reg;
    logic [N_W-1:0]   fill_reg, fill_old_reg;
    logic [TS_W-1:0]  ring_mem [WINDOW];
    logic [TS_W-1:0]  bank_a [WINDOW];
    logic [TS_W-1:0]  bank_b [WINDOW];
    logic [TS_W-1:0]  rdata_a, rdata_b;
    logic             sel_reg;

    // merge pass
    logic [N_W-1:0]   rd_idx_reg, rd_idx_next, wr_idx_reg;
    logic             ins_reg, rm_reg;
    logic [N_W-1:0]   r50_reg, r95_reg, r99_reg;
    logic [TS_W-1:0]  p50_reg, p95_reg, p99_reg;

    logic [TS_W-1:0]  dt_w, jit_w, cur, wr_val;
    logic             have_cur, adv, do_wr, set_ins, set_rm;
    logic [N_W-1:0]   wr_pos1;
    logic [24:0]      div_tmp;
    logic [TS_W:0]    psum_w;
    logic [CW-1:0]    run_w;
    logic [lpjm_pkg::RES_W-1:0] out_reg;

    assign dt_w  = now_reg - last_reg;
    assign jit_w = (dt_w > TS_W'(tgt_reg)) ? dt_w - TS_W'(tgt_reg) : TS_W'(tgt_reg) - dt_w;

    assign sts.valid     = valid_reg;
    assign sts.overrun   = (tgt_reg != '0) && (dt_reg > TS_W'(tgt_reg));
    assign sts.div_done  = (div_cnt_reg == DIV_W'(TS_W));
    assign sts.pass_done = (rd_idx_reg == fill_old_reg) && ins_reg;

    assign div_tmp = {rem_reg, quo_reg[TS_W-1]};
    assign psum_w  = {1'b0, psum_reg} + {1'b0, quo_reg};
    assign run_w   = (run_reg != CNT_MAX) ? run_reg + 1'b1 : CNT_MAX;
    assign wr_pos1 = wr_idx_reg + 1'b1;

    // merge step: drop the evicted value, insert the new interval in order
    always_comb begin
        have_cur = (rd_idx_reg != fill_old_reg);
        cur      = sel_reg ? rdata_b : rdata_a;
        adv      = 1'b0;
        do_wr    = 1'b0;
        set_ins  = 1'b0;
        set_rm   = 1'b0;
        wr_val   = cur;
        if (have_cur) begin
            if (!ins_reg && dt_reg < cur) begin
                do_wr   = 1'b1;
                set_ins = 1'b1;
                wr_val  = dt_reg;
            end else if (fill_old_reg == N_FULL && !rm_reg && cur == evict_reg) begin
                set_rm = 1'b1;
                adv    = 1'b1;
            end else begin
                do_wr = 1'b1;
                adv   = 1'b1;
            end
        end else if (!ins_reg) begin
            do_wr   = 1'b1;
            set_ins = 1'b1;
            wr_val  = dt_reg;
        end
        do_wr   = do_wr && cmd.pass_step;
        set_ins = set_ins && cmd.pass_step;
        set_rm  = set_rm && cmd.pass_step;
        adv     = adv && cmd.pass_step;
    end

    // read address of the sorted bank
    always_comb begin
        if (cmd.rank) begin
            rd_idx_next = '0;
        end else if (adv) begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end else begin
            rd_idx_next = rd_idx_reg;
        end
    end

    // sorted window banks, read one, write the other
    always_ff @(posedge aclk) begin
        rdata_a <= bank_a[rd_idx_next[IDX_W-1:0]];
        rdata_b <= bank_b[rd_idx_next[IDX_W-1:0]];
        if (do_wr && sel_reg) begin
            bank_a[wr_idx_reg[IDX_W-1:0]] <= wr_val;
        end
        if (do_wr && !sel_reg) begin
            bank_b[wr_idx_reg[IDX_W-1:0]] <= wr_val;
        end
    end

    // interval ring
    always_ff @(posedge aclk) begin
        if (cmd.meas) begin
            evict_reg <= ring_mem[pos_reg];
        end
        if (cmd.upd) begin
            ring_mem[pos_reg] <= dt_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            now_reg <= s_tdata;
        end
        if (cmd.meas) begin
            dt_reg  <= (last_reg != '0) ? dt_w : '0;
            rem_reg <= '0;
            quo_reg <= dt_w;
        end
        if (cmd.div_step) begin
            if (div_tmp >= 25'(tgt_reg)) begin
                rem_reg <= 24'(div_tmp - 25'(tgt_reg));
                quo_reg <= {quo_reg[TS_W-2:0], 1'b1};
            end else begin
                rem_reg <= div_tmp[23:0];
                quo_reg <= {quo_reg[TS_W-2:0], 1'b0};
            end
        end
        if (cmd.rank) begin
            r50_reg <= N_W'(lpjm_pkg::rank_of(lpjm_pkg::RANK_W'(fill_reg), lpjm_pkg::PCT_50));
            r95_reg <= N_W'(lpjm_pkg::rank_of(lpjm_pkg::RANK_W'(fill_reg), lpjm_pkg::PCT_95));
            r99_reg <= N_W'(lpjm_pkg::rank_of(lpjm_pkg::RANK_W'(fill_reg), lpjm_pkg::PCT_99));
        end
        if (cmd.fin) begin
            out_reg <= {7'd0, p99_reg, p95_reg, p50_reg, cross_reg, rpk_reg, run_reg,
                        psum_reg, oev_reg, WS_W'(fill_reg), jpk_reg, dt_reg, valid_reg};
        end
    end

    assign m_tdata = out_reg;

    // control state and statistics
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_reg     <= lpjm_pkg::TGT_RST;
            thr_reg     <= lpjm_pkg::THR_RST;
            last_reg    <= '0;
            valid_reg   <= 1'b0;
            jpk_reg     <= '0;
            psum_reg    <= '0;
            oev_reg     <= '0;
            run_reg     <= '0;
            rpk_reg     <= '0;
            cross_reg   <= '0;
            div_cnt_reg <= '0;
            pos_reg     <= '0;
            fill_reg    <= '0;
            fill_old_reg <= '0;
            sel_reg     <= 1'b0;
            rd_idx_reg  <= '0;
            wr_idx_reg  <= '0;
            ins_reg     <= 1'b0;
            rm_reg      <= 1'b0;
            p50_reg     <= '0;
            p95_reg     <= '0;
            p99_reg     <= '0;
        end else begin
            // configuration writes
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    lpjm_pkg::CFG_TARGET: tgt_reg <= cfg_wr_data;
                    lpjm_pkg::CFG_THRESH: thr_reg <= cfg_wr_data[lpjm_pkg::THR_W-1:0];
                    default: ;
                endcase
            end
            // measure interval and jitter
            if (cmd.meas) begin
                valid_reg   <= (last_reg != '0);
                last_reg    <= now_reg;
                div_cnt_reg <= '0;
                if (last_reg != '0 && jit_w > jpk_reg) begin
                    jpk_reg <= jit_w;
                end
            end
            if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            // overrun stats and ring bookkeeping
            if (cmd.upd) begin
                pos_reg      <= (pos_reg == POS_END) ? '0 : pos_reg + 1'b1;
                fill_old_reg <= fill_reg;
                if (fill_reg != N_FULL) begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (sts.overrun) begin
                    oev_reg  <= (oev_reg != CNT_MAX) ? oev_reg + 1'b1 : CNT_MAX;
                    psum_reg <= psum_w[TS_W] ? TS_MAX : psum_w[TS_W-1:0];
                    run_reg  <= run_w;
                    if (run_w > rpk_reg) begin
                        rpk_reg <= run_w;
                    end
                    if (run_w == CW'(thr_reg) && cross_reg != CNT_MAX) begin
                        cross_reg <= cross_reg + 1'b1;
                    end
                end else begin
                    run_reg <= '0;
                end
            end
            // merge pass
            if (cmd.rank) begin
                wr_idx_reg <= '0;
                ins_reg    <= 1'b0;
                rm_reg     <= 1'b0;
            end
            rd_idx_reg <= rd_idx_next;
            if (set_ins) begin
                ins_reg <= 1'b1;
            end
            if (set_rm) begin
                rm_reg <= 1'b1;
            end
            if (do_wr) begin
                wr_idx_reg <= wr_pos1;
                if (wr_pos1 == r50_reg) p50_reg <= wr_val;
                if (wr_pos1 == r95_reg) p95_reg <= wr_val;
                if (wr_pos1 == r99_reg) p99_reg <= wr_val;
            end
            if (cmd.swap) begin
                sel_reg <= ~sel_reg;
            end
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= N_FULL)
        else $error("window fill above depth");

    a_wr_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pass_step |-> (wr_idx_reg <= rd_idx_reg + 1'b1))
        else $error("merge write ran ahead of read");

    a_swap_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.swap |-> (wr_idx_reg == fill_reg))
        else $error("merged window size mismatch");

endmodule

// ----- sv/loop_period_jitter_monitor.sv -----
// loop_period_jitter_monitor: top level, timestamp in, jitter and overrun stats out
// depends on lpjm_pkg, lpjm_ctrl and lpjm_dp
//
//   channel   direction  payload
//   s_        in         timestamp_us
//   m_        out        interval result with stats and percentiles
//   cfg_      in         target_period_us, hard_overrun_threshold
//
// first item after reset or zero stamp: accept, measure, then result load
// measured item: accept, measure, bit-serial divide on overrun, update, rank,
//   merge over the prior window fill, load; the sorted-window merge moves one entry a cycle
// reset: synchronous, no clearing pass; result stays until m_tready
// one item at a time; s_tready is high only between items
module loop_period_jitter_monitor #(
    parameter int WINDOW = lpjm_pkg::WINDOW_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lpjm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpjm_pkg::TGT_W-1:0]      cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lpjm_pkg::TS_W-1:0]       s_tdata,  // timestamp_us
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // interval_valid, interval_us, jitter_max_us, window_samples, overrun_events,
    // overrun_periods, overrun_run_length, max_consecutive, escalation_crossings,
    // median_us, p95_us, p99_us
    output logic [lpjm_pkg::RES_W-1:0]      m_tdata
);

    lpjm_pkg::ctrl_cmd_t cmd;
    lpjm_pkg::dp_sts_t   sts;

    lpjm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpjm_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
